FILE: sv/camera_view_projection_matrices_defines.svh
// Assertion macros shared by the camera matrix modules.
`ifndef CAMERA_VIEW_PROJECTION_MATRICES_DEFINES_SVH
`define CAMERA_VIEW_PROJECTION_MATRICES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CVPM_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CVPM_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: sv/cvpm_pkg.sv
// Shared types, constants and helpers of the camera matrix block.
package cvpm_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] diff_t;

  typedef struct packed {
    word_t [2:0] p;
    diff_t [2:0] d;
  } cvpm_item_t;

  typedef struct packed {
    word_t [2:0] ax;
    word_t [2:0] ay;
    word_t [2:0] az;
    word_t [2:0] p;
    word_t [2:0] tr;
    word_t       w;
    word_t       h;
    word_t       rng;
    word_t       rn;
    logic        deg;
  } cvpm_mat_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [30:0] data;
  } cvpm_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
    logic        neg;
  } cvpm_div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
  } cvpm_div_rsp_t;

  localparam logic [1:0] REG_FOV_Y  = 2'd0;
  localparam logic [1:0] REG_ASPECT = 2'd1;
  localparam logic [1:0] REG_NEAR   = 2'd2;
  localparam logic [1:0] REG_FAR    = 2'd3;

  localparam logic [17:0] FOV_Y_RST  = 18'd51472;
  localparam logic [20:0] ASPECT_RST = 21'd116508;
  localparam logic [30:0] NEAR_RST   = 31'd655;
  localparam logic [30:0] FAR_RST    = 31'd65536000;

  localparam word_t WORD_MAX = 32'sh7FFFFFFF;
  localparam word_t WORD_MIN = 32'sh80000000;

  localparam int          CORDIC_STEPS = 30;
  localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;
  localparam logic [40:0] PI_Q30       = 41'd3373259426;
  localparam logic [40:0] HALF_PI_Q30  = 41'd1686629713;

  function automatic logic [31:0] mag32(input word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      5'd24: a = 30'd63;
      5'd25: a = 30'd31;
      5'd26: a = 30'd15;
      5'd27: a = 30'd7;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return {3'b000, a};
  endfunction

endpackage

FILE: sv/cvpm_front.sv
// Input side: accepts camera requests, forms the view direction, two-entry queue.
`include "camera_view_projection_matrices_defines.svh"
module cvpm_front
  import cvpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  word_t      pos_x,
  input  word_t      pos_y,
  input  word_t      pos_z,
  input  word_t      target_x,
  input  word_t      target_y,
  input  word_t      target_z,
  output cvpm_item_t item,
  output logic       item_valid,
  input  logic       item_pop
);

  cvpm_item_t  qmem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  cvpm_item_t  new_item;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = qmem[rd_ptr];
  assign do_push    = push && !full;

  always_comb begin
    new_item.p[0] = pos_x;
    new_item.p[1] = pos_y;
    new_item.p[2] = pos_z;
    new_item.d[0] = {pos_x[31], pos_x} - {target_x[31], target_x};
    new_item.d[1] = {pos_y[31], pos_y} - {target_y[31], target_y};
    new_item.d[2] = {pos_z[31], pos_z} - {target_z[31], target_z};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      qmem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, item_pop};
    end
  end

  `CVPM_ASSERT_IMP(a_pop_needs_entry, item_pop, count != 2'd0, "pop from empty queue")
  `CVPM_ASSERT_NEXT(a_push_grows, do_push && !item_pop, count == $past(count) + 2'd1,
    "queue count did not grow on push")

endmodule

FILE: sv/cvpm_div.sv
// Iterative restoring divider, one quotient bit per cycle, rounds to nearest.
module cvpm_div
  import cvpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cvpm_div_req_t req,
  output cvpm_div_rsp_t rsp
);

  localparam int STEPS = 64;
  localparam int CW    = $clog2(STEPS + 1);

  logic [63:0]   n_reg;
  logic [63:0]   q_reg;
  logic [32:0]   rem;
  logic [32:0]   den_reg;
  logic          neg_reg;
  logic [CW-1:0] cnt;
  logic          done;
  logic [33:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem, n_reg[63]};
  assign fits   = (rem_sh >= {1'b0, den_reg});

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_reg   <= req.num + {32'd0, req.den[32:1]};
      den_reg <= req.den;
      neg_reg <= req.neg;
      rem     <= '0;
      q_reg   <= '0;
    end else if (cnt != '0) begin
      n_reg <= {n_reg[62:0], 1'b0};
      q_reg <= {q_reg[62:0], fits};
      rem   <= fits ? 33'(rem_sh - {1'b0, den_reg}) : rem_sh[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (req.start) begin
        cnt <= CW'(STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Saturate the signed quotient to a word.
  always_comb begin
    rsp.done = done;
    if (!neg_reg) begin
      rsp.quot = (q_reg > 64'h7FFFFFFF) ? WORD_MAX : word_t'(q_reg[31:0]);
    end else begin
      rsp.quot = (q_reg > 64'h80000000) ? WORD_MIN : word_t'(~q_reg[31:0] + 32'd1);
    end
  end

endmodule

FILE: sv/cvpm_engine.sv
// Back end: sequencer that builds the camera, view and projection matrices.
`include "camera_view_projection_matrices_defines.svh"
module cvpm_engine
  import cvpm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cvpm_cfg_t  cfg,
  input  cvpm_item_t item,
  input  logic       item_valid,
  output logic       item_pop,
  output cvpm_mat_t  res,
  output logic       res_valid,
  input  logic       res_ready
);

  localparam int          SHL = (FRAC_BITS <= 29) ? 29 - FRAC_BITS : 0;
  localparam int          SHR = (FRAC_BITS > 29) ? FRAC_BITS - 29 : 0;
  localparam logic [67:0] RND = 68'd1 << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NSCALE, S_NSQ, S_NSQRT, S_NDIV, S_NCX, S_DWAIT, S_MAC, S_MACFIN,
    S_PRED, S_PREFL, S_PCORD, S_PCOT, S_PW, S_PRANGE, S_DONE
  } state_t;

  typedef enum logic [1:0] { DT_NORM, DT_COT, DT_ASP, DT_RNG } div_tag_t;

  state_t   state;
  div_tag_t tag;

  logic [17:0] fov;
  logic [20:0] asp;
  logic [30:0] nearp;
  logic [30:0] farp;

  logic [2:0][31:0] va;
  logic [2:0]       vs;
  word_t [2:0]      pv, az, ax, ay, tr;
  word_t            h, w, rng, rn;
  logic             deg;
  logic             pass;
  logic [1:0]       k;
  logic [2:0]       j;
  logic [63:0]      sumsq, sq_n, sq_res, sq_bit;
  logic [4:0]       sq_cnt;
  logic [31:0]      len;

  logic signed [65:0] prod;
  logic               prod_sub;
  logic signed [67:0] acc;

  logic [40:0]        theta;
  logic [2:0]         rk;
  logic               negc;
  logic signed [33:0] cxr, cyr;
  logic signed [32:0] czr;
  logic [4:0]         ci;

  cvpm_div_req_t dreq;
  cvpm_div_rsp_t drsp;

  cvpm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fov   <= FOV_Y_RST;
      asp   <= ASPECT_RST;
      nearp <= NEAR_RST;
      farp  <= FAR_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_FOV_Y:  fov   <= cfg.data[17:0];
        REG_ASPECT: asp   <= cfg.data[20:0];
        REG_NEAR:   nearp <= cfg.data;
        REG_FAR:    farp  <= cfg.data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [32:0] ext33(input word_t v);
    return {v[31], v};
  endfunction

  // Shared datapath helpers
  logic [31:0]        mx, va_k;
  logic               vs_k;
  logic [1:0]         nterms;
  logic signed [32:0] ma, mb;
  logic               msub, mneg;
  logic signed [67:0] acc_add;
  logic [63:0]        sq_t, sq_res_next;
  logic               sq_fit;
  logic [67:0]        acc_mag, rmag;
  logic               rneg;
  word_t              mac_out;
  logic [40:0]        piv;
  logic signed [33:0] cdx, cdy, cval;
  logic [33:0]        cmag;
  logic signed [31:0] diff;

  always_comb begin
    mx = va[0];
    if (va[1] > mx) mx = va[1];
    if (va[2] > mx) mx = va[2];
    case (k)
      2'd0: begin va_k = va[0]; vs_k = vs[0]; end
      2'd1: begin va_k = va[1]; vs_k = vs[1]; end
      2'd2: begin va_k = va[2]; vs_k = vs[2]; end
      default: begin va_k = '0; vs_k = 1'b0; end
    endcase
  end

  // Operand selection for the multiplier
  always_comb begin
    ma     = '0;
    mb     = '0;
    msub   = 1'b0;
    mneg   = (j == 3'd3) || (j == 3'd4) || (j == 3'd5);
    nterms = (j < 3'd3) ? 2'd2 : ((j < 3'd6) ? 2'd3 : 2'd1);
    if (state == S_NSQ) begin
      ma = {1'b0, va_k};
      mb = {1'b0, va_k};
    end else begin
      case (j)
        3'd0: begin
          ma   = (k == 2'd0) ? ext33(az[1]) : ext33(az[2]);
          mb   = (k == 2'd0) ? ext33(ax[2]) : ext33(ax[1]);
          msub = (k != 2'd0);
        end
        3'd1: begin
          ma   = (k == 2'd0) ? ext33(az[2]) : ext33(az[0]);
          mb   = (k == 2'd0) ? ext33(ax[0]) : ext33(ax[2]);
          msub = (k != 2'd0);
        end
        3'd2: begin
          ma   = (k == 2'd0) ? ext33(az[0]) : ext33(az[1]);
          mb   = (k == 2'd0) ? ext33(ax[1]) : ext33(ax[0]);
          msub = (k != 2'd0);
        end
        3'd3, 3'd4, 3'd5: begin
          case (k)
            2'd0:    mb = ext33(pv[0]);
            2'd1:    mb = ext33(pv[1]);
            default: mb = ext33(pv[2]);
          endcase
          case ({j, k})
            {3'd3, 2'd0}: ma = ext33(ax[0]);
            {3'd3, 2'd1}: ma = ext33(ax[1]);
            {3'd3, 2'd2}: ma = ext33(ax[2]);
            {3'd4, 2'd0}: ma = ext33(ay[0]);
            {3'd4, 2'd1}: ma = ext33(ay[1]);
            {3'd4, 2'd2}: ma = ext33(ay[2]);
            {3'd5, 2'd0}: ma = ext33(az[0]);
            {3'd5, 2'd1}: ma = ext33(az[1]);
            {3'd5, 2'd2}: ma = ext33(az[2]);
            default:      ma = '0;
          endcase
        end
        default: begin
          ma = ext33(rng);
          mb = {2'b00, nearp};
        end
      endcase
    end
  end

  always_comb begin
    acc_add = prod_sub ? (acc - {{2{prod[65]}}, prod}) : (acc + {{2{prod[65]}}, prod});
    sq_t    = sq_res + sq_bit;
    sq_fit  = (sq_n >= sq_t);
    sq_res_next = sq_fit ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    // Round to nearest, ties away from zero, then saturate
    acc_mag = acc[67] ? 68'(-acc) : 68'(acc);
    rmag    = (acc_mag + RND) >> FRAC_BITS;
    rneg    = acc[67] ^ mneg;
    if (!rneg) begin
      mac_out = (rmag > 68'h7FFFFFFF) ? WORD_MAX : word_t'(rmag[31:0]);
    end else begin
      mac_out = (rmag > 68'h80000000) ? WORD_MIN : word_t'(~rmag[31:0] + 32'd1);
    end
    piv  = PI_Q30 << rk;
    cdx  = cyr >>> ci;
    cdy  = cxr >>> ci;
    cval = negc ? -cxr : cxr;
    cmag = cval[33] ? 34'(-cval) : 34'(cval);
    diff = $signed({1'b0, nearp}) - $signed({1'b0, farp});
  end

  // Divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    dreq.neg   = 1'b0;
    case (state)
      S_NDIV: begin
        dreq.start = 1'b1;
        dreq.num   = 64'(va_k) << FRAC_BITS;
        dreq.den   = {1'b0, len};
        dreq.neg   = vs_k;
      end
      S_PCOT: begin
        dreq.start = !cyr[33] && (cyr != '0);
        dreq.num   = 64'(cmag) << FRAC_BITS;
        dreq.den   = cyr[32:0];
        dreq.neg   = cval[33];
      end
      S_PW: begin
        dreq.start = (asp != '0);
        dreq.num   = 64'(mag32(h)) << FRAC_BITS;
        dreq.den   = 33'(asp);
        dreq.neg   = h[31];
      end
      S_PRANGE: begin
        dreq.start = (diff != '0);
        dreq.num   = 64'(farp) << FRAC_BITS;
        dreq.den   = {1'b0, mag32(diff)};
        dreq.neg   = diff[31];
      end
      default: ;
    endcase
  end

  assign item_pop  = (state == S_IDLE) && item_valid;
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.ax  = ax;
    res.ay  = ay;
    res.az  = az;
    res.p   = pv;
    res.tr  = tr;
    res.w   = w;
    res.h   = h;
    res.rng = rng;
    res.rn  = rn;
    res.deg = deg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tag   <= DT_NORM;
      pass  <= 1'b0;
      k     <= '0;
      j     <= '0;
      deg   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            for (int i = 0; i < 3; i++) begin
              pv[i] <= item.p[i];
              vs[i] <= item.d[i][32];
              va[i] <= item.d[i][32] ? 32'(-item.d[i]) : item.d[i][31:0];
            end
            pass  <= 1'b0;
            deg   <= 1'b0;
            state <= S_NSCALE;
          end
        end
        // Bring the largest magnitude into [2^29, 2^30), one bit a cycle
        S_NSCALE: begin
          if (mx == '0) begin
            if (!pass) begin
              az    <= '0;
              state <= S_NCX;
            end else begin
              ax    <= '0;
              deg   <= 1'b1;
              j     <= 3'd0;
              k     <= 2'd0;
              acc   <= '0;
              state <= S_MAC;
            end
          end else if (mx >= 32'h40000000) begin
            for (int i = 0; i < 3; i++) va[i] <= va[i] >> 1;
          end else if (mx < 32'h20000000) begin
            for (int i = 0; i < 3; i++) va[i] <= va[i] << 1;
          end else begin
            k     <= 2'd0;
            sumsq <= '0;
            state <= S_NSQ;
          end
        end
        S_NSQ: begin
          prod     <= ma * mb;
          prod_sub <= 1'b0;
          if (k != 2'd0) begin
            sumsq <= sumsq + prod[63:0];
          end
          if (k == 2'd2 + 2'd1) begin
            sq_n   <= sumsq + prod[63:0];
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= '0;
            state  <= S_NSQRT;
          end
          k <= k + 2'd1;
        end
        S_NSQRT: begin
          if (sq_fit) begin
            sq_n <= sq_n - sq_t;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            len   <= sq_res_next[31:0];
            k     <= 2'd0;
            state <= S_NDIV;
          end
        end
        S_NDIV: begin
          tag   <= DT_NORM;
          state <= S_DWAIT;
        end
        // Side axis comes from +Y crossed with the forward axis
        S_NCX: begin
          va[0] <= mag32(az[2]);
          vs[0] <= az[2][31];
          va[1] <= '0;
          vs[1] <= 1'b0;
          va[2] <= mag32(az[0]);
          vs[2] <= !az[0][31] && (az[0] != '0);
          pass  <= 1'b1;
          state <= S_NSCALE;
        end
        S_DWAIT: begin
          if (drsp.done) begin
            case (tag)
              DT_NORM: begin
                if (pass) ax[k] <= drsp.quot;
                else      az[k] <= drsp.quot;
                if (k == 2'd2) begin
                  if (!pass) begin
                    state <= S_NCX;
                  end else begin
                    j     <= 3'd0;
                    k     <= 2'd0;
                    acc   <= '0;
                    state <= S_MAC;
                  end
                end else begin
                  k     <= k + 2'd1;
                  state <= S_NDIV;
                end
              end
              DT_COT: begin
                h     <= drsp.quot;
                state <= S_PW;
              end
              DT_ASP: begin
                w     <= drsp.quot;
                state <= S_PRANGE;
              end
              default: begin
                rng   <= drsp.quot;
                j     <= 3'd6;
                k     <= 2'd0;
                acc   <= '0;
                state <= S_MAC;
              end
            endcase
          end
        end
        S_MAC: begin
          if (k < nterms) begin
            prod     <= ma * mb;
            prod_sub <= msub;
          end
          if (k != 2'd0) begin
            acc <= acc_add;
          end
          if (k == nterms) begin
            state <= S_MACFIN;
          end
          k <= k + 2'd1;
        end
        S_MACFIN: begin
          case (j)
            3'd0: ay[0] <= mac_out;
            3'd1: ay[1] <= mac_out;
            3'd2: ay[2] <= mac_out;
            3'd3: tr[0] <= mac_out;
            3'd4: tr[1] <= mac_out;
            3'd5: tr[2] <= mac_out;
            default: rn <= mac_out;
          endcase
          k   <= 2'd0;
          acc <= '0;
          if (j == 3'd5) begin
            theta <= (41'(fov) << SHL) >> SHR;
            rk    <= 3'd7;
            state <= S_PRED;
          end else if (j == 3'd6) begin
            state <= S_DONE;
          end else begin
            j     <= j + 3'd1;
            state <= S_MAC;
          end
        end
        // Reduce the half angle modulo pi, one binary step a cycle
        S_PRED: begin
          if (theta >= piv) begin
            theta <= theta - piv;
          end
          rk <= rk - 3'd1;
          if (rk == 3'd0) begin
            state <= S_PREFL;
          end
        end
        S_PREFL: begin
          negc <= (theta > HALF_PI_Q30);
          czr  <= (theta > HALF_PI_Q30) ? 33'(PI_Q30 - theta) : 33'(theta);
          cxr  <= CORDIC_GAIN;
          cyr  <= '0;
          ci   <= '0;
          state <= S_PCORD;
        end
        S_PCORD: begin
          if (!czr[32]) begin
            cxr <= cxr - cdx;
            cyr <= cyr + cdy;
            czr <= czr - atan_q30(ci);
          end else begin
            cxr <= cxr + cdx;
            cyr <= cyr - cdy;
            czr <= czr + atan_q30(ci);
          end
          ci <= ci + 5'd1;
          if (ci == 5'(CORDIC_STEPS - 1)) begin
            state <= S_PCOT;
          end
        end
        S_PCOT: begin
          if (cyr[33] || (cyr == '0)) begin
            h     <= cval[33] ? WORD_MIN : ((cval != '0) ? WORD_MAX : '0);
            state <= S_PW;
          end else begin
            tag   <= DT_COT;
            state <= S_DWAIT;
          end
        end
        S_PW: begin
          if (asp == '0) begin
            w     <= h[31] ? WORD_MIN : ((h != '0) ? WORD_MAX : '0);
            state <= S_PRANGE;
          end else begin
            tag   <= DT_ASP;
            state <= S_DWAIT;
          end
        end
        S_PRANGE: begin
          if (diff == '0) begin
            rng   <= '0;
            deg   <= 1'b1;
            j     <= 3'd6;
            k     <= 2'd0;
            acc   <= '0;
            state <= S_MAC;
          end else begin
            tag   <= DT_RNG;
            state <= S_DWAIT;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CVPM_ASSERT_IMP(a_div_done_in_wait, drsp.done, state == S_DWAIT,
    "divider finished outside its wait state")
  `CVPM_ASSERT_IMP(a_pop_when_idle, item_pop, item_valid && !res_valid,
    "queue popped while a result is pending")

endmodule

FILE: sv/cvpm_rows.sv
// Result side: holds one finished matrix set and hands it out row by row.
`include "camera_view_projection_matrices_defines.svh"
module cvpm_rows
  import cvpm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cvpm_mat_t  mat,
  input  logic       mat_valid,
  output logic       mat_ready,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] matrix_select,
  output logic [1:0] row_index,
  output word_t      elem0,
  output word_t      elem1,
  output word_t      elem2,
  output word_t      elem3,
  output logic       degenerate,
  output logic       last_row
);

  localparam word_t ONE = 32'(64'd1 << FRAC_BITS);

  cvpm_mat_t  bank;
  logic       busy;
  logic [3:0] row;
  logic       take;

  assign empty     = !busy;
  assign last_row  = (row == 4'd11);
  assign take      = pop && busy;
  assign mat_ready = !busy || (take && last_row);

  assign matrix_select = row[3:2];
  assign row_index     = row[1:0];
  assign degenerate    = bank.deg;

  always_comb begin
    elem0 = '0;
    elem1 = '0;
    elem2 = '0;
    elem3 = '0;
    case (row)
      4'd0:  begin elem0 = bank.ax[0]; elem1 = bank.ax[1]; elem2 = bank.ax[2]; end
      4'd1:  begin elem0 = bank.ay[0]; elem1 = bank.ay[1]; elem2 = bank.ay[2]; end
      4'd2:  begin elem0 = bank.az[0]; elem1 = bank.az[1]; elem2 = bank.az[2]; end
      4'd3:  begin
        elem0 = bank.p[0]; elem1 = bank.p[1]; elem2 = bank.p[2]; elem3 = ONE;
      end
      4'd4:  begin elem0 = bank.ax[0]; elem1 = bank.ay[0]; elem2 = bank.az[0]; end
      4'd5:  begin elem0 = bank.ax[1]; elem1 = bank.ay[1]; elem2 = bank.az[1]; end
      4'd6:  begin elem0 = bank.ax[2]; elem1 = bank.ay[2]; elem2 = bank.az[2]; end
      4'd7:  begin
        elem0 = bank.tr[0]; elem1 = bank.tr[1]; elem2 = bank.tr[2]; elem3 = ONE;
      end
      4'd8:  elem0 = bank.w;
      4'd9:  elem1 = bank.h;
      4'd10: begin elem2 = bank.rng; elem3 = -ONE; end
      4'd11: elem2 = bank.rn;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mat_valid && mat_ready) begin
      bank <= mat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else begin
      if (take) begin
        if (last_row) begin
          busy <= 1'b0;
          row  <= '0;
        end else begin
          row <= row + 4'd1;
        end
      end
      if (mat_valid && mat_ready) begin
        busy <= 1'b1;
        row  <= '0;
      end
    end
  end

  `CVPM_ASSERT_NEXT(a_run_ends, take && last_row && !mat_valid, !busy,
    "row output did not drain after the last projection row")

endmodule

FILE: sv/camera_view_projection_matrices.sv
// Top level of the camera world, view and projection matrix block.
//
//   channel   handshake          payload
//   input     push / full        pos_x..z, target_x..z
//   result    pop / empty        matrix_select, row_index, elem0..3, degenerate, last_row
//   config    cfg_we             cfg_index, cfg_data
//
// In the back end, the nine divisions of a request on the shared divider dominate
// its work, plus two square roots of 32 steps, the 30-step CORDIC and a
// one-bit-a-cycle normalizing shift of each vector.
// Twelve rows then leave at one per cycle, as they are popped, while the next
// request is worked on; two requests can wait in the input queue. Reset is
// synchronous; a stalled result row holds on the ports until popped.
module camera_view_projection_matrices
  import cvpm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  word_t       pos_x,
  input  word_t       pos_y,
  input  word_t       pos_z,
  input  word_t       target_x,
  input  word_t       target_y,
  input  word_t       target_z,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  matrix_select,
  output logic [1:0]  row_index,
  output word_t       elem0,
  output word_t       elem1,
  output word_t       elem2,
  output word_t       elem3,
  output logic        degenerate,
  output logic        last_row,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cvpm_item_t item;
  logic       item_valid;
  logic       item_pop;
  cvpm_mat_t  mat;
  logic       mat_valid;
  logic       mat_ready;
  cvpm_cfg_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  cvpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .target_x   (target_x),
    .target_y   (target_y),
    .target_z   (target_z),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  cvpm_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res        (mat),
    .res_valid  (mat_valid),
    .res_ready  (mat_ready)
  );

  cvpm_rows #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rows (
    .clk           (clk),
    .rst           (rst),
    .mat           (mat),
    .mat_valid     (mat_valid),
    .mat_ready     (mat_ready),
    .empty         (empty),
    .pop           (pop),
    .matrix_select (matrix_select),
    .row_index     (row_index),
    .elem0         (elem0),
    .elem1         (elem1),
    .elem2         (elem2),
    .elem3         (elem3),
    .degenerate    (degenerate),
    .last_row      (last_row)
  );

endmodule
